@@ sv/htd_pkg.sv @@
// Shared types and constants for the hashed trie dictionary unit.
package htd_pkg;

  localparam int unsigned HASH_MUL = 100;

  // Input kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Per-word status carried between characters
  typedef struct packed {
    logic miss;
    logic stop;
    logic full;
  } word_flags_t;

endpackage

@@ sv/htd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/hashed_trie_dictionary_unit.sv @@
// Top level of the hashed trie dictionary unit: sequencer plus table memories.
//
//  channel  | dir | fields
//  s_axis   | in  | tdata: symbol[7:0]; tlast: last; tuser: kind
//  m_axis   | out | tdata: found[0], full_res[1], nodes_used[11:2]
//  cfg      | in  | data: node_limit[9:0]
//
// A character goes through accept, bucket head read, one pool read per chain
// link, resolve, then the end-mark check; an empty bucket skips the pool reads.
// A character of a word that has already stopped goes from accept straight to
// the end-mark check.
// After reset a clearing pass writes every bucket head and end mark to zero,
// and during it s_axis_tready is low.
// cfg is always ready.
// A waiting result does not stop the next character; a character with last
// waits only while the output register is still full.
module hashed_trie_dictionary_unit #(
  parameter int MAX_NODES = 512,
  parameter int BUCKETS   = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // symbol[7:0]
  input  logic        s_axis_tlast,   // last
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // found, full_res, nodes_used[9:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int BW = $clog2(BUCKETS);
  localparam int CW = NW + 1;            // node count, holds MAX_NODES
  localparam int PW = NW + 8 + NW;       // start, symbol, next
  localparam int HW = NW + 7 + 1 + 8;    // product width for hash
  localparam int CLR_N = (BUCKETS > MAX_NODES) ? BUCKETS : MAX_NODES;
  localparam int CCW = $clog2(CLR_N) + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HEAD  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_PRD   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]  state;
  logic [CCW-1:0] clr_cnt;
  logic [9:0]  node_limit;
  logic [CW-1:0] next_free;
  logic [NW-1:0] cur;
  htd_pkg::word_flags_t flags;

  // item latched for the current character
  logic       kind;
  logic [7:0] sym;
  logic       lst;
  logic [BW-1:0] bucket;
  logic [NW-1:0] entry;   // chain entry being examined
  logic [NW-1:0] head;
  logic          hit_seen; // chain walk ended on a matching entry

  // memories
  logic          bh_we, pl_we, em_we;
  logic [BW-1:0] bh_waddr, bh_raddr;
  logic [NW-1:0] bh_wdata, bh_rdata;
  logic [NW-1:0] pl_waddr, pl_raddr;
  logic [PW-1:0] pl_wdata, pl_rdata;
  logic [NW-1:0] em_waddr, em_raddr;
  logic          em_wdata;
  logic [0:0]    em_rdata;

  htd_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_bucket (
    .clk, .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(bh_raddr), .rdata(bh_rdata));
  htd_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_pool (
    .clk, .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(pl_raddr), .rdata(pl_rdata));
  htd_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_endm (
    .clk, .we(em_we), .waddr(em_waddr), .wdata(em_wdata),
    .raddr(em_raddr), .rdata(em_rdata));

  // effective limit clamped to 1..MAX_NODES
  logic [CW-1:0] lim;
  always_comb begin
    if (node_limit == 10'd0) begin
      lim = CW'(1);
    end else if (32'(node_limit) > 32'(MAX_NODES)) begin
      lim = CW'(MAX_NODES);
    end else begin
      lim = CW'(node_limit);
    end
  end

  // hash of incoming symbol with current node
  logic [HW-1:0] hash_full;
  assign hash_full = HW'(cur) * HW'(htd_pkg::HASH_MUL) + HW'(s_axis_tdata);

  logic in_acc;
  assign s_axis_tready = (state == ST_IDLE) && !(s_axis_tlast && m_axis_tvalid);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // pool entry fields
  logic [NW-1:0] pe_start, pe_next;
  logic [7:0]    pe_sym;
  assign {pe_start, pe_sym, pe_next} = pl_rdata;
  logic hit;
  assign hit = (pe_start == cur) && (pe_sym == sym);

  logic can_alloc;
  assign can_alloc = next_free < lim;

  // memory access control
  always_comb begin
    bh_we = 1'b0; bh_waddr = bucket; bh_wdata = NW'(next_free);
    bh_raddr = hash_full[BW-1:0];
    pl_we = 1'b0; pl_waddr = NW'(next_free); pl_wdata = {cur, sym, head};
    pl_raddr = bh_rdata;
    em_we = 1'b0; em_waddr = cur; em_wdata = 1'b1; em_raddr = cur;
    unique case (state)
      ST_CLEAR: begin
        bh_we = clr_cnt < CCW'(BUCKETS);
        bh_waddr = clr_cnt[BW-1:0]; bh_wdata = '0;
        em_we = clr_cnt < CCW'(MAX_NODES);
        em_waddr = clr_cnt[NW-1:0]; em_wdata = 1'b0;
      end
      ST_HEAD: pl_raddr = bh_rdata;
      ST_WALK: pl_raddr = pe_next;
      ST_PRD: begin
        // end mark of the node the walk lands on, valid in ST_DONE
        em_raddr = hit_seen ? entry : cur;
        if (!hit_seen && kind == htd_pkg::KIND_INSERT && can_alloc) begin
          bh_we = 1'b1; pl_we = 1'b1;
          em_we = 1'b1; em_waddr = NW'(next_free); em_wdata = 1'b0;
        end
      end
      ST_DONE: begin
        em_we = lst && kind == htd_pkg::KIND_INSERT && !flags.stop;
      end
      default: ;
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && lst) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      node_limit <= 10'd512;
      next_free <= CW'(1);
      cur <= '0;
      flags <= '0;
    end else begin
      if (cfg_valid) begin
        node_limit <= cfg_data;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CCW'(CLR_N - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            kind <= s_axis_tuser;
            sym <= s_axis_tdata;
            lst <= s_axis_tlast;
            bucket <= hash_full[BW-1:0];
            state <= flags.stop ? ST_DONE : ST_HEAD;
          end
        end
        ST_HEAD: begin
          // bucket head now valid; pool read issued for head entry
          head <= bh_rdata;
          entry <= bh_rdata;
          hit_seen <= 1'b0;
          state <= (bh_rdata == '0) ? ST_PRD : ST_WALK;
        end
        ST_WALK: begin
          // pool data for entry valid; the match is kept for ST_PRD
          if (hit || pe_next == '0) begin
            hit_seen <= hit;
            state <= ST_PRD;
          end else begin
            entry <= pe_next;
          end
        end
        ST_PRD: begin
          // resolve transition
          if (hit_seen) begin
            cur <= entry;
          end else if (kind == htd_pkg::KIND_LOOKUP) begin
            flags.miss <= 1'b1; flags.stop <= 1'b1;
          end else if (can_alloc) begin
            cur <= NW'(next_free);
            next_free <= next_free + 1'b1;
            flags.miss <= 1'b1;
          end else begin
            flags.full <= 1'b1; flags.stop <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          // end-mark read of cur is valid here
          if (lst) begin
            m_axis_tdata <= {4'd0, 10'(next_free),
                             flags.full,
                             !flags.miss && !flags.stop && em_rdata[0]};
            cur <= '0;
            flags <= '0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A result stays in the output register until it has been taken.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped");
  // Node count never passes the pool size.
  assert property (@(posedge clk) disable iff (rst)
    32'(next_free) <= 32'(MAX_NODES))
    else $error("node count overflow");
  // No item taken during the clearing pass.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_axis_tready)
    else $error("item during clear");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the hashed trie dictionary unit.
module tb_top;

  localparam int MAX_NODES = 512;
  localparam int BUCKETS   = 1024;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic       found;
    logic       full_res;
    logic [9:0] nodes_used;
  } word_answer_t;

  // Trie model and store of expected word answers
  class trie_scoreboard;
    logic [9:0]  head_tab [BUCKETS];
    logic [9:0]  from_node [MAX_NODES];
    logic [7:0]  via_sym [MAX_NODES];
    logic [9:0]  chain_next [MAX_NODES];
    bit          word_end [MAX_NODES];
    int unsigned free_node, cur_node, limit_reg;
    bit          miss_f, stop_f, full_f;
    word_answer_t answers[$];
    int          errors;

    function new();
      for (int i = 0; i < BUCKETS; i++) head_tab[i] = '0;
      for (int i = 0; i < MAX_NODES; i++) word_end[i] = 0;
      free_node = 1; cur_node = 0; limit_reg = 512;
      miss_f = 0; stop_f = 0; full_f = 0; errors = 0;
    endfunction

    function void set_limit(logic [9:0] v);
      limit_reg = v;
    endfunction

    // Advance the walk by one character; queue an answer on the last one
    function void note_char(logic kind, logic [7:0] sym, logic lst);
      int unsigned lim, bkt, e, hit;
      word_answer_t a;
      lim = (limit_reg < 1) ? 1 : (limit_reg > MAX_NODES ? MAX_NODES : limit_reg);
      if (!stop_f) begin
        bkt = (cur_node * htd_pkg::HASH_MUL + sym) % BUCKETS;
        e = head_tab[bkt];
        hit = 0;
        while (e != 0 && hit == 0) begin
          if (from_node[e] == cur_node && via_sym[e] == sym) hit = e;
          else e = chain_next[e];
        end
        if (hit != 0) begin
          cur_node = hit;
        end else if (kind == htd_pkg::KIND_LOOKUP) begin
          miss_f = 1; stop_f = 1;
        end else if (free_node < lim) begin
          from_node[free_node] = cur_node;
          via_sym[free_node] = sym;
          chain_next[free_node] = head_tab[bkt];
          word_end[free_node] = 0;
          head_tab[bkt] = free_node;
          cur_node = free_node;
          free_node++;
          miss_f = 1;
        end else begin
          full_f = 1; stop_f = 1;
        end
      end
      if (lst) begin
        a.found = !miss_f && !stop_f && word_end[cur_node];
        if (kind == htd_pkg::KIND_INSERT && !stop_f) word_end[cur_node] = 1;
        a.full_res = full_f;
        a.nodes_used = free_node[9:0];
        answers.push_back(a);
        cur_node = 0; miss_f = 0; stop_f = 0; full_f = 0;
      end
    endfunction

    task check_answer(logic [15:0] d);
      word_answer_t want;
      if (answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", d));
        return;
      end
      want = answers.pop_front();
      if (d[0] !== want.found)
        report_mismatch($sformatf("found %b want %b", d[0], want.found));
      if (d[1] !== want.full_res)
        report_mismatch($sformatf("full_res %b want %b", d[1], want.full_res));
      if (d[11:2] !== want.nodes_used)
        report_mismatch($sformatf("nodes_used %0d want %0d", d[11:2], want.nodes_used));
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask
  endclass

  logic        clk = 0, rst = 1;
  logic        s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid, m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 0, cfg_ready;
  logic [9:0]  cfg_data = '0;

  trie_scoreboard dict = new();
  int  idle_pct = 11;
  int  quiet_cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  hashed_trie_dictionary_unit #(.MAX_NODES(MAX_NODES), .BUCKETS(BUCKETS)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Result side: random stall, check each accepted word answer
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) dict.check_answer(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Send one character, with a random idle gap in front; valid stays high
  // after acceptance until the next character or an idle cycle replaces it
  task automatic send_char(logic kind, logic [7:0] sym, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= sym;
    s_axis_tlast <= lst;
    do @(posedge clk); while (!s_axis_tready);
    dict.note_char(kind, sym, lst);
  endtask

  task automatic send_word(logic kind, logic [7:0] w[$]);
    foreach (w[i]) send_char(kind, w[i], i == w.size() - 1);
  endtask

  task automatic drain_answers();
    s_axis_tvalid <= 0;
    while (dict.answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [9:0] v);
    drain_answers();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    dict.set_limit(v);
    cfg_valid <= 0;
  endtask

  // Make a word of 1 to 5 symbols, from a small alphabet when vocab is set so that repeats and shared prefixes occur
  function automatic void make_word(ref logic [7:0] w[$], input int vocab);
    int len;
    w.delete();
    len = $urandom_range(1, 5);
    for (int i = 0; i < len; i++)
      w.push_back(vocab ? 8'($urandom_range(97, 100)) : 8'($urandom));
  endfunction

  initial begin
    logic [7:0] w[$];
    int sent;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extreme symbols, insert then lookup, mixed kinds, misses
    w = '{8'h00, 8'hFF}; send_word(htd_pkg::KIND_INSERT, w);
    send_word(htd_pkg::KIND_INSERT, w);
    send_word(htd_pkg::KIND_LOOKUP, w);
    w = '{8'h00}; send_word(htd_pkg::KIND_LOOKUP, w);
    w = '{8'h55, 8'hAA, 8'h01}; send_word(htd_pkg::KIND_LOOKUP, w);
    send_char(htd_pkg::KIND_INSERT, 8'h55, 0);
    send_char(htd_pkg::KIND_LOOKUP, 8'hAA, 0);
    send_char(htd_pkg::KIND_INSERT, 8'h01, 1);
    send_char(htd_pkg::KIND_INSERT, 8'h55, 0);
    send_char(htd_pkg::KIND_LOOKUP, 8'h77, 1);

    // Node pool exhaustion and limit below nodes in use
    write_limit(10'd1);
    w = '{8'h10, 8'h20}; send_word(htd_pkg::KIND_INSERT, w);
    w = '{8'h00, 8'hFF}; send_word(htd_pkg::KIND_INSERT, w);
    write_limit(10'd8);
    w = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35}; send_word(htd_pkg::KIND_INSERT, w);
    write_limit(10'd0);
    send_word(htd_pkg::KIND_INSERT, w);
    w = '{8'h41}; send_word(htd_pkg::KIND_INSERT, w);
    write_limit(10'd1023);
    drain_answers();

    // Random: mostly words from a small alphabet, some full-byte noise
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 2) ? 0 : 11;
      if (phase == 1) write_limit(10'($urandom_range(60, 200)));
      if (phase == 3) write_limit(10'd512);
      while (sent < (phase + 1) * 450) begin
        make_word(w, $urandom_range(99) < 80);
        if ($urandom_range(99) < 15) begin
          foreach (w[i]) send_char(1'($urandom), w[i], i == w.size() - 1);
        end else begin
          send_word($urandom_range(99) < 55 ? htd_pkg::KIND_INSERT
                                            : htd_pkg::KIND_LOOKUP, w);
        end
        sent += w.size();
      end
      drain_answers();
    end

    if (dict.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
